>>> hdl/nbpi_pkg.sv
// shared types, constants and microcode formats of the ntt base-pair inverse unit
// no dependencies; used by every module under hdl
package nbpi_pkg;

   localparam int DATA_W = 16;

   localparam int unsigned MODULUS_Q     = 3457;
   localparam int unsigned MONT_SCALE    = 867;
   localparam int          BARRETT_SHIFT = 10;

   // newton iteration for q^-1 mod 2^16
   function automatic logic [15:0] qinv_calc(input int unsigned q);
      int unsigned x;
      x = q;
      for (int i = 0; i < 4; i++) begin
         x = (x * ((32'd2 - q * x) & 32'h0000_ffff)) & 32'h0000_ffff;
      end
      return x[15:0];
   endfunction

   localparam int unsigned BARRETT_RAW = ((32'd1 << 26) + MODULUS_Q / 2) / MODULUS_Q;

   localparam logic signed [DATA_W-1:0] Q16         = DATA_W'(MODULUS_Q);
   localparam logic signed [DATA_W-1:0] QINV        = qinv_calc(MODULUS_Q);
   localparam logic signed [DATA_W-1:0] BARRETT_MUL = DATA_W'(BARRETT_RAW);
   localparam logic signed [DATA_W-1:0] K_SCALE     = DATA_W'(MONT_SCALE);

   // exponent q-2 for the fermat inverse
   localparam int EXP_W = $clog2(MODULUS_Q);
   localparam logic [EXP_W-1:0] E_INIT = EXP_W'(MODULUS_Q - 2);

   // microcode program addresses
   localparam int PC_W     = 4;
   localparam int PROG_LEN = 9;
   localparam logic [PC_W-1:0] UC_A1SQ  = 4'd0;
   localparam logic [PC_W-1:0] UC_ZMUL  = 4'd1;
   localparam logic [PC_W-1:0] UC_DET   = 4'd2;
   localparam logic [PC_W-1:0] UC_BRED  = 4'd3;
   localparam logic [PC_W-1:0] UC_SCALE = 4'd4;
   localparam logic [PC_W-1:0] UC_TMUL  = 4'd5;
   localparam logic [PC_W-1:0] UC_XSQ   = 4'd6;
   localparam logic [PC_W-1:0] UC_OUT0  = 4'd7;
   localparam logic [PC_W-1:0] UC_OUT1  = 4'd8;

   typedef enum logic [2:0] {
      SRC_A0,
      SRC_A1,
      SRC_NA1,
      SRC_NZ,
      SRC_X,
      SRC_Y,
      SRC_T,
      SRC_K
   } src_sel_type;

   typedef enum logic [2:0] {
      DST_X,
      DST_Y,
      DST_T,
      DST_R0,
      DST_R1
   } dst_sel_type;

   typedef enum logic {
      MODE_MONT,
      MODE_BARRETT
   } mul_mode_type;

   typedef struct packed {
      src_sel_type  src_x;
      src_sel_type  src_y;
      mul_mode_type mode;
      dst_sel_type  dest;
      logic         add_y;
      logic         cond_e;
      logic         shift_e;
      logic         jump_nz;
      logic [PC_W-1:0] jump_to;
      logic         done;
   } ucode_word_type;

   typedef struct packed {
      logic         issue;
      mul_mode_type mode;
   } mul_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FLUSH
   } seq_state_type;

endpackage

>>> hdl/ntt_base_pair_inverse_mod_q_unit.sv
// inverse of one ntt-domain pair a0 + a1*X modulo X^2 - zeta over Z_q
// inverse runs 7 + 2*bitlen(q-2) micro-steps (31 for q = 3457) through the one shared
// multiplier; a new pair is accepted only once the sequencer has handed its result to the output register
// the next pair is accepted while a finished result waits in the output register
// reset (synchronous, active high) idles the sequencer, empties the output and clears the
// sticky failure flag
module ntt_base_pair_inverse_mod_q_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // coef_even [15:0], coef_odd [31:16], root_value [47:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // inv_even [15:0], inv_odd [31:16]
   output logic [1:0]  rsp_tuser,   // pair_singular [0], poly_failed [1]
   output logic        rsp_tlast
);

   nbpi_pkg::seq_state_type state_ff, state_in;
   logic [nbpi_pkg::PC_W-1:0] pc_ff, pc_in;
   logic [1:0]                phase_ff, phase_in;
   logic [nbpi_pkg::EXP_W-1:0] e_ff, e_in;
   logic                      fail_seen_ff, fail_seen_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      last_ff;

   logic signed [nbpi_pkg::DATA_W-1:0] a0_ff, a1_ff, na1_ff, nz_ff, x_ff, y_ff, t_ff;
   logic signed [nbpi_pkg::DATA_W-1:0] r0_ff, r1_ff;
   logic signed [nbpi_pkg::DATA_W-1:0] op_x, op_y, mul_res, wb_val;
   logic [31:0]         rsp_data_ff;
   logic [1:0]          rsp_user_ff;
   logic                rsp_last_ff;

   nbpi_pkg::ucode_word_type uword;
   nbpi_pkg::mul_ctl_type    mctl;

   logic req_fire, issue, step_end, wb_en, load_out, jump_take, sing;

   nbpi_ucode_rom u_rom (
      .pc   (pc_ff),
      .word (uword)
   );

   nbpi_mul_unit u_mul (
      .clock  (clock),
      .ctl    (mctl),
      .op_x   (op_x),
      .op_y   (op_y),
      .result (mul_res)
   );

   // control outputs
   always_comb begin
      req_tready = (state_ff == nbpi_pkg::ST_IDLE);
      issue      = (state_ff == nbpi_pkg::ST_RUN) && (phase_ff == 2'd0);
      step_end   = (state_ff == nbpi_pkg::ST_RUN) && (phase_ff == 2'd2);
      load_out   = (state_ff == nbpi_pkg::ST_FLUSH) && (!rsp_valid_ff || rsp_tready);
   end

   assign req_fire  = req_tvalid && req_tready;
   assign wb_en     = step_end && (!uword.cond_e || e_ff[0]);
   assign jump_take = uword.jump_nz && (e_ff[nbpi_pkg::EXP_W-1:1] != '0);
   assign mctl      = '{issue: issue, mode: uword.mode};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         nbpi_pkg::ST_IDLE: begin
            if (req_fire) state_in = nbpi_pkg::ST_RUN;
         end
         nbpi_pkg::ST_RUN: begin
            if (step_end && uword.done) state_in = nbpi_pkg::ST_FLUSH;
         end
         nbpi_pkg::ST_FLUSH: begin
            if (load_out) state_in = nbpi_pkg::ST_IDLE;
         end
         default: state_in = nbpi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      pc_in    = pc_ff;
      e_in     = e_ff;
      if (req_fire) begin
         phase_in = 2'd0;
         pc_in    = nbpi_pkg::UC_A1SQ;
         e_in     = nbpi_pkg::E_INIT;
      end else if (state_ff == nbpi_pkg::ST_RUN) begin
         if (step_end) begin
            phase_in = 2'd0;
            pc_in    = jump_take ? uword.jump_to : pc_ff + 1'b1;
            if (uword.shift_e) e_in = e_ff >> 1;
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end
   end

   always_comb begin
      case (uword.src_x)
         nbpi_pkg::SRC_A0:  op_x = a0_ff;
         nbpi_pkg::SRC_A1:  op_x = a1_ff;
         nbpi_pkg::SRC_NA1: op_x = na1_ff;
         nbpi_pkg::SRC_NZ:  op_x = nz_ff;
         nbpi_pkg::SRC_X:   op_x = x_ff;
         nbpi_pkg::SRC_Y:   op_x = y_ff;
         nbpi_pkg::SRC_T:   op_x = t_ff;
         nbpi_pkg::SRC_K:   op_x = nbpi_pkg::K_SCALE;
         default:           op_x = x_ff;
      endcase
      case (uword.src_y)
         nbpi_pkg::SRC_A0:  op_y = a0_ff;
         nbpi_pkg::SRC_A1:  op_y = a1_ff;
         nbpi_pkg::SRC_NA1: op_y = na1_ff;
         nbpi_pkg::SRC_NZ:  op_y = nz_ff;
         nbpi_pkg::SRC_X:   op_y = x_ff;
         nbpi_pkg::SRC_Y:   op_y = y_ff;
         nbpi_pkg::SRC_T:   op_y = t_ff;
         nbpi_pkg::SRC_K:   op_y = nbpi_pkg::K_SCALE;
         default:           op_y = x_ff;
      endcase
   end

   assign wb_val = uword.add_y ? mul_res + y_ff : mul_res;

   // operand and work registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         a0_ff   <= req_tdata[15:0];
         a1_ff   <= req_tdata[31:16];
         na1_ff  <= -$signed(req_tdata[31:16]);
         nz_ff   <= -$signed(req_tdata[47:32]);
         last_ff <= req_tlast;
         t_ff    <= nbpi_pkg::DATA_W'(1);
      end else if (wb_en) begin
         case (uword.dest)
            nbpi_pkg::DST_X:  x_ff  <= wb_val;
            nbpi_pkg::DST_Y:  y_ff  <= wb_val;
            nbpi_pkg::DST_T:  t_ff  <= wb_val;
            nbpi_pkg::DST_R0: r0_ff <= wb_val;
            nbpi_pkg::DST_R1: r1_ff <= wb_val;
            default:          x_ff  <= wb_val;
         endcase
      end
   end

   assign sing = (t_ff == '0);

   always_comb begin
      fail_seen_in = fail_seen_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         fail_seen_in = last_ff ? 1'b0 : (fail_seen_ff | sing);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= {r1_ff, r0_ff};
         rsp_user_ff <= {fail_seen_ff | sing, sing};
         rsp_last_ff <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nbpi_pkg::ST_IDLE;
         pc_ff        <= nbpi_pkg::UC_A1SQ;
         phase_ff     <= 2'd0;
         e_ff         <= '0;
         fail_seen_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         phase_ff     <= phase_in;
         e_ff         <= e_in;
         fail_seen_ff <= fail_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser[0] || rsp_tuser[1]))
      else $error("poly_failed low while pair_singular set");

   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !$rose(rsp_tvalid))
      else $error("result raised right after accept");

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == nbpi_pkg::ST_RUN) |-> (pc_ff < nbpi_pkg::PC_W'(nbpi_pkg::PROG_LEN)))
      else $error("microcode address out of program");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("step phase out of range");

endmodule

>>> hdl/nbpi_ucode_rom.sv
// microcode program of the pair inverse: determinant, barrett, scaling, fermat loop, outputs
// depends on nbpi_pkg
module nbpi_ucode_rom (
   input  logic [nbpi_pkg::PC_W-1:0] pc,
   output nbpi_pkg::ucode_word_type  word
);

   always_comb begin
      word = '{src_x: nbpi_pkg::SRC_X, src_y: nbpi_pkg::SRC_X, mode: nbpi_pkg::MODE_MONT,
               dest: nbpi_pkg::DST_Y, add_y: 1'b0, cond_e: 1'b0, shift_e: 1'b0,
               jump_nz: 1'b0, jump_to: nbpi_pkg::UC_A1SQ, done: 1'b0};
      case (pc)
         nbpi_pkg::UC_A1SQ: begin
            word.src_x = nbpi_pkg::SRC_A1;
            word.src_y = nbpi_pkg::SRC_A1;
            word.dest  = nbpi_pkg::DST_Y;
         end
         nbpi_pkg::UC_ZMUL: begin
            word.src_x = nbpi_pkg::SRC_Y;
            word.src_y = nbpi_pkg::SRC_NZ;
            word.dest  = nbpi_pkg::DST_Y;
         end
         nbpi_pkg::UC_DET: begin
            word.src_x = nbpi_pkg::SRC_A0;
            word.src_y = nbpi_pkg::SRC_A0;
            word.dest  = nbpi_pkg::DST_X;
            word.add_y = 1'b1;
         end
         nbpi_pkg::UC_BRED: begin
            word.src_x = nbpi_pkg::SRC_X;
            word.mode  = nbpi_pkg::MODE_BARRETT;
            word.dest  = nbpi_pkg::DST_X;
         end
         nbpi_pkg::UC_SCALE: begin
            word.src_x = nbpi_pkg::SRC_X;
            word.src_y = nbpi_pkg::SRC_K;
            word.dest  = nbpi_pkg::DST_X;
         end
         nbpi_pkg::UC_TMUL: begin
            word.src_x  = nbpi_pkg::SRC_T;
            word.src_y  = nbpi_pkg::SRC_X;
            word.dest   = nbpi_pkg::DST_T;
            word.cond_e = 1'b1;
         end
         nbpi_pkg::UC_XSQ: begin
            word.src_x   = nbpi_pkg::SRC_X;
            word.src_y   = nbpi_pkg::SRC_X;
            word.dest    = nbpi_pkg::DST_X;
            word.shift_e = 1'b1;
            word.jump_nz = 1'b1;
            word.jump_to = nbpi_pkg::UC_TMUL;
         end
         nbpi_pkg::UC_OUT0: begin
            word.src_x = nbpi_pkg::SRC_A0;
            word.src_y = nbpi_pkg::SRC_T;
            word.dest  = nbpi_pkg::DST_R0;
         end
         nbpi_pkg::UC_OUT1: begin
            word.src_x = nbpi_pkg::SRC_NA1;
            word.src_y = nbpi_pkg::SRC_T;
            word.dest  = nbpi_pkg::DST_R1;
            word.done  = 1'b1;
         end
         default: begin
            word.done = 1'b1;
         end
      endcase
   end

endmodule

>>> hdl/nbpi_mul_unit.sv
// shared multiply unit: montgomery multiply or barrett reduction
// depends on nbpi_pkg; result is combinational from the t2/base2 register, which is fed from the p1 register
module nbpi_mul_unit (
   input  logic                                clock,
   input  nbpi_pkg::mul_ctl_type               ctl,
   input  logic signed [nbpi_pkg::DATA_W-1:0]  op_x,
   input  logic signed [nbpi_pkg::DATA_W-1:0]  op_y,
   output logic signed [nbpi_pkg::DATA_W-1:0]  result
);

   logic signed [2*nbpi_pkg::DATA_W-1:0] p1_ff, p1_in;
   logic signed [nbpi_pkg::DATA_W-1:0]   x1_ff, y_eff;
   nbpi_pkg::mul_mode_type               mode1_ff, mode2_ff;
   logic signed [nbpi_pkg::DATA_W-1:0]   t2_ff, t2_in, base2_ff, base2_in;
   logic signed [nbpi_pkg::DATA_W-1:0]   p1_hi, p1_lo, sub3;
   logic signed [2*nbpi_pkg::DATA_W-1:0] qi_prod, q_prod;

   assign y_eff = (ctl.mode == nbpi_pkg::MODE_BARRETT) ? nbpi_pkg::BARRETT_MUL : op_y;
   assign p1_in = op_x * y_eff;

   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         p1_ff    <= p1_in;
         x1_ff    <= op_x;
         mode1_ff <= ctl.mode;
      end
   end

   assign p1_hi   = p1_ff[2*nbpi_pkg::DATA_W-1:nbpi_pkg::DATA_W];
   assign p1_lo   = p1_ff[nbpi_pkg::DATA_W-1:0];
   assign qi_prod = nbpi_pkg::QINV * p1_lo;

   always_comb begin
      if (mode1_ff == nbpi_pkg::MODE_BARRETT) begin
         t2_in    = p1_hi >>> nbpi_pkg::BARRETT_SHIFT;
         base2_in = x1_ff;
      end else begin
         t2_in    = qi_prod[nbpi_pkg::DATA_W-1:0];
         base2_in = p1_hi;
      end
   end

   always_ff @(posedge clock) begin
      t2_ff    <= t2_in;
      base2_ff <= base2_in;
      mode2_ff <= mode1_ff;
   end

   assign q_prod = nbpi_pkg::Q16 * t2_ff;
   assign sub3   = (mode2_ff == nbpi_pkg::MODE_BARRETT) ?
                   q_prod[nbpi_pkg::DATA_W-1:0] :
                   q_prod[2*nbpi_pkg::DATA_W-1:nbpi_pkg::DATA_W];
   assign result = base2_ff - sub3;

endmodule

>>> tb/pair_inverse_checker.sv
`timescale 1ns / 1ps
// checker for the ntt base-pair inverse unit: predicts every response transaction from the
// accepted request transactions and compares it field by field with what comes out
// depends only on the two stream channels it watches; reports pending and error counts
module pair_inverse_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // coef_even [15:0], coef_odd [31:16], root_value [47:32]
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // inv_even [15:0], inv_odd [31:16]
   input  logic [1:0]  rsp_tuser,   // pair_singular [0], poly_failed [1]
   input  logic        rsp_tlast,
   output int          n_pending,
   output int          n_errors
);

   localparam int      MOD_Q       = 3457;
   localparam shortint Q_S         = shortint'(MOD_Q);
   localparam shortint TO_MONT     = 867;
   localparam int      BARRETT_SHR = 10;

   // lifts the inverse of an odd q one bit at a time
   function automatic shortint hensel_qinv(input int q);
      int x;
      x = 1;
      for (int i = 1; i < 16; i++) begin
         if (((q * x) >> i) & 1) x = x | (1 << i);
      end
      return shortint'(x);
   endfunction

   localparam shortint QINV_S    = hensel_qinv(MOD_Q);
   localparam shortint BARRETT_K = shortint'(((1 << 26) + MOD_Q / 2) / MOD_Q);

   typedef struct packed {
      logic signed [15:0] inv_even;
      logic signed [15:0] inv_odd;
      logic               singular;
      logic               failed;
      logic               last;
   } pair_inverse_type;

   function automatic shortint mont_mul(input shortint a, input shortint b);
      int      prod, corr;
      shortint m, r;
      prod = int'(a) * int'(b);
      m    = shortint'(int'(shortint'(prod)) * int'(QINV_S));
      corr = int'(Q_S) * int'(m);
      r    = shortint'(prod >>> 16) - shortint'(corr >>> 16);
      return r;
   endfunction

   function automatic shortint barrett_reduce(input shortint a);
      shortint t, r;
      t = shortint'((int'(BARRETT_K) * int'(a)) >>> 16);
      t = t >>> BARRETT_SHR;
      t = shortint'(int'(Q_S) * int'(t));
      r = a - t;
      return r;
   endfunction

   // fermat inverse, exponent bits taken from the low end
   function automatic shortint fermat_inverse(input shortint d);
      shortint acc, base, prod;
      int      e;
      acc  = 1;
      base = mont_mul(d, TO_MONT);
      e    = MOD_Q - 2;
      while (e > 0) begin
         prod = mont_mul(acc, base);
         if (e & 1) acc = prod;
         base = mont_mul(base, base);
         e    = e >> 1;
      end
      return acc;
   endfunction

   function automatic pair_inverse_type invert_pair(input logic [47:0] data, input logic last);
      shortint          a0, a1, nz, na1, det;
      pair_inverse_type res;
      a0  = data[15:0];
      a1  = data[31:16];
      nz  = -shortint'(data[47:32]);
      na1 = -a1;
      det = mont_mul(mont_mul(a1, a1), nz);
      det = det + mont_mul(a0, a0);
      det = barrett_reduce(det);
      det = fermat_inverse(det);
      res.inv_even = mont_mul(a0, det);
      res.inv_odd  = mont_mul(na1, det);
      res.singular = (det == 0);
      res.failed   = 1'b0;
      res.last     = last;
      return res;
   endfunction

   pair_inverse_type expected_inverses[$];
   logic             fail_seen = 1'b0;
   int               err_count = 0;

   task automatic report(input string fld, input logic signed [31:0] want,
                         input logic signed [31:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
      err_count++;
   endtask

   always @(posedge clock) begin : watch
      pair_inverse_type want;
      logic signed [15:0] got_even, got_odd;
      if (reset) begin
         fail_seen = 1'b0;
         expected_inverses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_even = rsp_tdata[15:0];
            got_odd  = rsp_tdata[31:16];
            if (expected_inverses.size() == 0) begin
               $display("%0t: response transaction with none expected, inv_even %0d inv_odd %0d",
                        $time, got_even, got_odd);
               err_count++;
            end else begin
               want = expected_inverses.pop_front();
               if (got_even !== want.inv_even) report("inv_even", want.inv_even, got_even);
               if (got_odd !== want.inv_odd) report("inv_odd", want.inv_odd, got_odd);
               if (rsp_tuser[0] !== want.singular)
                  report("pair_singular", want.singular, rsp_tuser[0]);
               if (rsp_tuser[1] !== want.failed)
                  report("poly_failed", want.failed, rsp_tuser[1]);
               if (rsp_tlast !== want.last) report("last_out", want.last, rsp_tlast);
            end
         end
         if (req_tvalid && req_tready) begin
            want        = invert_pair(req_tdata, req_tlast);
            want.failed = fail_seen | want.singular;
            fail_seen   = req_tlast ? 1'b0 : want.failed;
            expected_inverses.push_back(want);
         end
      end
      n_pending <= expected_inverses.size();
      n_errors  <= err_count;
   end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// top of the ntt base-pair inverse unit testbench: clock, reset, directed and random pairs,
// random stalls on both channels; depends on the unit and on pair_inverse_checker
module tb_top;

   localparam int Q_VAL       = 3457;
   localparam int N_RANDOM    = 1130;
   localparam int HOLD_CYCLES = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // coef_even [15:0], coef_odd [31:16], root_value [47:32]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // inv_even [15:0], inv_odd [31:16]
   logic [1:0]  rsp_tuser;         // pair_singular [0], poly_failed [1]
   logic        rsp_tlast;

   logic hold_out = 1'b0;
   logic quiet    = 1'b0;
   int   n_pending;
   int   n_errors;

   ntt_base_pair_inverse_mod_q_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   pair_inverse_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .n_pending  (n_pending),
      .n_errors   (n_errors)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #10_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // mostly full-range values, some in the range -q to q, a few at the extremes
   function automatic logic [15:0] pick_coef();
      int unsigned sel;
      sel = $urandom_range(0, 19);
      if (sel < 14) return 16'($urandom);
      if (sel < 17) return 16'(int'($urandom_range(0, 2 * Q_VAL)) - Q_VAL);
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'hffff;
         3: return 16'h0001;
         default: return 16'h0000;
      endcase
   endfunction

   task automatic send_pair(input logic [15:0] a0, input logic [15:0] a1,
                            input logic [15:0] zeta, input logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {zeta, a1, a0};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // receiver: random stalls, one long hold-off on request, none in the quiet part
   initial begin : rsp_side
      @(posedge clock);
      forever begin
         if (hold_out) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_out = 1'b0;
         end else if (quiet || $urandom_range(0, 5) != 0) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int          sent, plen, k0, k1;
      logic [15:0] a0, a1, zeta;
      logic        lst;
      sent = 0;
      @(posedge clock iff !reset);

      // sticky failure across a polynomial, cleared after its last pair
      send_pair(16'sd0, 16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd1, 16'sd0, 16'sd0, 1'b0);
      send_pair(16'sd1234, -16'sd567, 16'sd17, 1'b1);
      send_pair(16'sd1, 16'sd0, 16'sd0, 1'b1);
      // extremes and negation wrap of the most negative value
      send_pair(16'sd32767, 16'sd32767, 16'sd32767, 1'b0);
      send_pair(16'h8000, 16'h8000, 16'h8000, 1'b0);
      send_pair(16'h8000, 16'sd32767, 16'sd1, 1'b0);
      send_pair(16'sd32767, 16'h8000, -16'sd1, 1'b0);
      send_pair(16'sd0, 16'h8000, 16'sd1, 1'b0);
      send_pair(-16'sd1, -16'sd1, -16'sd1, 1'b0);
      send_pair(16'sd0, 16'sd1, 16'sd17, 1'b0);
      // zero inverse from multiples of q, three of them on last pairs; the other pairs here are not multiples of q
      send_pair(16'sd3457, 16'sd6914, -16'sd1234, 1'b1);
      send_pair(-16'sd31113, 16'sd0, 16'sd5, 1'b0);
      send_pair(16'sd0, 16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd17, 16'sd0, -16'sd17, 1'b1);
      send_pair(16'sd3456, 16'sd1, 16'sd3456, 1'b0);
      send_pair(-16'sd3457, -16'sd3457, 16'sd32767, 1'b1);
      send_pair(16'h5555, 16'haaaa, 16'h2aaa, 1'b0);
      send_pair(16'haaaa, 16'h5555, 16'hd555, 1'b1);

      while (sent < N_RANDOM) begin
         plen = $urandom_range(1, 12);
         for (int i = 0; i < plen; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               k0 = int'($urandom_range(0, 18)) - 9;
               k1 = int'($urandom_range(0, 18)) - 9;
               a0 = 16'(k0 * Q_VAL);
               a1 = 16'(k1 * Q_VAL);
            end else begin
               a0 = pick_coef();
               a1 = pick_coef();
            end
            zeta = pick_coef();
            lst  = (i == plen - 1) || ($urandom_range(0, 49) == 0);
            send_pair(a0, a1, zeta, lst);
            sent++;
            if (sent == 300) hold_out = 1'b1;
            if (sent == 600) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               wait (n_pending == 0);
            end
            if (sent == N_RANDOM - 150) quiet = 1'b1;
         end
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (n_pending == 0);
      repeat (200) @(posedge clock);
      if (n_errors == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
